>>> rtl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, constants and the control-word table for the character LCD
// nibble interface sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  localparam int CfgWidth    = 16;
  localparam int WaitWidth   = 17;
  localparam int NibbleWidth = 4;
  localparam int ByteWidth   = 8;
  localparam int PcWidth     = 6;
  localparam int RegIdxWidth = 3;

  localparam logic [RegIdxWidth-1:0] REG_STARTUP_WAIT    = 3'd0;
  localparam logic [RegIdxWidth-1:0] REG_SECOND_KEY_WAIT = 3'd1;
  localparam logic [RegIdxWidth-1:0] REG_THIRD_KEY_WAIT  = 3'd2;
  localparam logic [RegIdxWidth-1:0] REG_BYTE_GAP_WAIT   = 3'd3;
  localparam logic [RegIdxWidth-1:0] REG_CLEAR_DONE_WAIT = 3'd4;

  localparam logic [CfgWidth-1:0] RST_STARTUP_WAIT    = 16'd15000;
  localparam logic [CfgWidth-1:0] RST_SECOND_KEY_WAIT = 16'd41000;
  localparam logic [CfgWidth-1:0] RST_THIRD_KEY_WAIT  = 16'd100;
  localparam logic [CfgWidth-1:0] RST_BYTE_GAP_WAIT   = 16'd40;
  localparam logic [CfgWidth-1:0] RST_CLEAR_DONE_WAIT = 16'd40000;

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_GOTO  = 2'd1,
    REQ_CHAR  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  // entry points into the control table
  localparam logic [PcWidth-1:0] PC_INIT     = 6'd0;
  localparam logic [PcWidth-1:0] PC_SEND_REQ = 6'd45;
  localparam int                 RomDepth    = 52;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1
  } seq_state_t;

  typedef enum logic [2:0] {
    W_ZERO       = 3'd0,
    W_GAP        = 3'd1,
    W_GAP_START  = 3'd2,
    W_GAP_SECOND = 3'd3,
    W_GAP_THIRD  = 3'd4,
    W_CLEAR      = 3'd5
  } wait_sel_t;

  typedef enum logic [1:0] {
    RS_KEEP = 2'd0,
    RS_ZERO = 2'd1,
    RS_REQ  = 2'd2
  } rs_op_t;

  typedef enum logic [1:0] {
    EN_KEEP = 2'd0,
    EN_HIGH = 2'd1,
    EN_LOW  = 2'd2
  } en_op_t;

  typedef enum logic [2:0] {
    D_KEEP   = 3'd0,
    D_ROM_HI = 3'd1,
    D_ROM_LO = 3'd2,
    D_REQ_HI = 3'd3,
    D_REQ_LO = 3'd4
  } dat_op_t;

  typedef struct packed {
    wait_sel_t             wait_sel;
    rs_op_t                rs_op;
    en_op_t                en_op;
    dat_op_t               dat_op;
    logic [ByteWidth-1:0]  konst;
    logic                  last;
  } ctrl_word_t;

  function automatic ctrl_word_t cw(wait_sel_t ws, rs_op_t rs, en_op_t en, dat_op_t d,
                                    logic [ByteWidth-1:0] k, logic last);
    ctrl_word_t w;
    w.wait_sel = ws;
    w.rs_op    = rs;
    w.en_op    = en;
    w.dat_op   = d;
    w.konst    = k;
    w.last     = last;
    return w;
  endfunction

  function automatic ctrl_word_t ctrl_rom(logic [PcWidth-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      // init keys
      6'd0:  w = cw(W_GAP_START,  RS_ZERO, EN_KEEP, D_KEEP,   8'h03, 1'b0);
      6'd1:  w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h03, 1'b0);
      6'd2:  w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_LO, 8'h03, 1'b0);
      6'd3:  w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h03, 1'b0);
      6'd4:  w = cw(W_GAP_SECOND, RS_ZERO, EN_KEEP, D_KEEP,   8'h03, 1'b0);
      6'd5:  w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h03, 1'b0);
      6'd6:  w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_LO, 8'h03, 1'b0);
      6'd7:  w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h03, 1'b0);
      6'd8:  w = cw(W_GAP_THIRD,  RS_ZERO, EN_KEEP, D_KEEP,   8'h03, 1'b0);
      6'd9:  w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h03, 1'b0);
      6'd10: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_LO, 8'h03, 1'b0);
      6'd11: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h03, 1'b0);
      6'd12: w = cw(W_GAP,        RS_ZERO, EN_KEEP, D_KEEP,   8'h02, 1'b0);
      6'd13: w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h02, 1'b0);
      6'd14: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_LO, 8'h02, 1'b0);
      6'd15: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h02, 1'b0);
      // function set
      6'd16: w = cw(W_GAP,        RS_ZERO, EN_KEEP, D_KEEP,   8'h28, 1'b0);
      6'd17: w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h28, 1'b0);
      6'd18: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_HI, 8'h28, 1'b0);
      6'd19: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h28, 1'b0);
      6'd20: w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h28, 1'b0);
      6'd21: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_LO, 8'h28, 1'b0);
      6'd22: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h28, 1'b0);
      // display on
      6'd23: w = cw(W_GAP,        RS_ZERO, EN_KEEP, D_KEEP,   8'h0C, 1'b0);
      6'd24: w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h0C, 1'b0);
      6'd25: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_HI, 8'h0C, 1'b0);
      6'd26: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h0C, 1'b0);
      6'd27: w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h0C, 1'b0);
      6'd28: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_LO, 8'h0C, 1'b0);
      6'd29: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h0C, 1'b0);
      // entry mode
      6'd30: w = cw(W_GAP,        RS_ZERO, EN_KEEP, D_KEEP,   8'h06, 1'b0);
      6'd31: w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h06, 1'b0);
      6'd32: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_HI, 8'h06, 1'b0);
      6'd33: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h06, 1'b0);
      6'd34: w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h06, 1'b0);
      6'd35: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_LO, 8'h06, 1'b0);
      6'd36: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h06, 1'b0);
      // clear
      6'd37: w = cw(W_GAP,        RS_ZERO, EN_KEEP, D_KEEP,   8'h01, 1'b0);
      6'd38: w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h01, 1'b0);
      6'd39: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_HI, 8'h01, 1'b0);
      6'd40: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h01, 1'b0);
      6'd41: w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h01, 1'b0);
      6'd42: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_ROM_LO, 8'h01, 1'b0);
      6'd43: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h01, 1'b0);
      6'd44: w = cw(W_CLEAR,      RS_KEEP, EN_KEEP, D_KEEP,   8'h00, 1'b1);
      // byte from the request
      6'd45: w = cw(W_GAP,        RS_REQ,  EN_KEEP, D_KEEP,   8'h00, 1'b0);
      6'd46: w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h00, 1'b0);
      6'd47: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_REQ_HI, 8'h00, 1'b0);
      6'd48: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h00, 1'b0);
      6'd49: w = cw(W_ZERO,       RS_KEEP, EN_HIGH, D_KEEP,   8'h00, 1'b0);
      6'd50: w = cw(W_ZERO,       RS_KEEP, EN_KEEP, D_REQ_LO, 8'h00, 1'b0);
      6'd51: w = cw(W_ZERO,       RS_KEEP, EN_LOW,  D_KEEP,   8'h00, 1'b1);
      default: w = cw(W_ZERO,     RS_KEEP, EN_KEEP, D_KEEP,   8'h00, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/char_lcd_nibble_interface_core.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_core
// Turns init, cursor and character requests into timed pin snapshots for a
// character LCD on a 4-bit bus.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per transfer. in_tuser carries the request kind
//            (init, goto, character); kind 3 is taken and dropped.
//   out_*  : one pin snapshot per transfer, out_tlast on the last one of a
//            request. out_tdata.wait_before tells the pin driver how many
//            cycles to hold before applying the snapshot.
//   cfg_*  : wait registers, to be written by the user only while no request
//            is in flight; the block itself does not enforce this.
// A table-driven step counter emits one snapshot per cycle, unless a stalled
// out_tready freezes it, into a single output register; no snapshot is lost.
// Goto and character requests take 7 snapshots, init 45. On acceptance the
// state and step counter load, then the output register takes the first
// snapshot. in_tready is high only when no request is in flight. Reset
// clears pin levels, sets wait registers to defaults, idles the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_interface_core
  import clcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // column[5:0], row[6], char_code[14:7]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // wait_before[16:0], en_pin[17], data_nibble[21:18]
  output logic             out_tuser,  // rs_pin[0]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_data
);

  logic [CfgWidth-1:0] startup_wait_r, second_key_wait_r, third_key_wait_r;
  logic [CfgWidth-1:0] byte_gap_wait_r, clear_done_wait_r;

  seq_state_t          state_r, state_nxt;
  logic [PcWidth-1:0]  pc_r, pc_nxt;
  logic [ByteWidth-1:0] req_byte_r;
  logic                req_rs_r;

  logic                   rs_r, rs_nxt;
  logic                   en_r, en_nxt;
  logic [NibbleWidth-1:0] dat_r, dat_nxt;

  logic                   out_valid_r;
  logic [WaitWidth-1:0]   out_wait_r;
  logic                   out_rs_r, out_en_r, out_last_r;
  logic [NibbleWidth-1:0] out_dat_r;

  ctrl_word_t          word;
  logic                in_xfer, exec, load_req;
  req_type_t           req;
  logic [CfgWidth-1:0] extra;
  logic [WaitWidth-1:0] wait_val;

  assign req      = req_type_t'(in_tuser);
  assign in_xfer  = in_tvalid && in_tready;
  assign word     = ctrl_rom(pc_r);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && req != REQ_NONE) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (exec && word.last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    exec      = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_RUN:  exec = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign load_req = in_xfer && req != REQ_NONE;

  always_comb begin
    pc_nxt = pc_r;
    if (load_req) begin
      pc_nxt = (req == REQ_INIT) ? PC_INIT : PC_SEND_REQ;
    end else if (exec) begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_comb begin
    unique case (word.wait_sel)
      W_GAP_START:  extra = startup_wait_r;
      W_GAP_SECOND: extra = second_key_wait_r;
      W_GAP_THIRD:  extra = third_key_wait_r;
      W_CLEAR:      extra = clear_done_wait_r;
      default:      extra = '0;
    endcase
    unique case (word.wait_sel)
      W_ZERO:  wait_val = '0;
      W_CLEAR: wait_val = {1'b0, extra};
      default: wait_val = {1'b0, extra} + {1'b0, byte_gap_wait_r};
    endcase
  end

  always_comb begin
    unique case (word.rs_op)
      RS_ZERO: rs_nxt = 1'b0;
      RS_REQ:  rs_nxt = req_rs_r;
      default: rs_nxt = rs_r;
    endcase
    unique case (word.en_op)
      EN_HIGH: en_nxt = 1'b1;
      EN_LOW:  en_nxt = 1'b0;
      default: en_nxt = en_r;
    endcase
    unique case (word.dat_op)
      D_ROM_HI: dat_nxt = word.konst[7:4];
      D_ROM_LO: dat_nxt = word.konst[3:0];
      D_REQ_HI: dat_nxt = req_byte_r[7:4];
      D_REQ_LO: dat_nxt = req_byte_r[3:0];
      default:  dat_nxt = dat_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      rs_r        <= 1'b0;
      en_r        <= 1'b0;
      dat_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      if (exec) begin
        rs_r        <= rs_nxt;
        en_r        <= en_nxt;
        dat_r       <= dat_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_req) begin
      req_rs_r   <= (req == REQ_CHAR);
      req_byte_r <= (req == REQ_CHAR) ? in_tdata[14:7] : {1'b1, in_tdata[6], in_tdata[5:0]};
    end
    if (exec) begin
      out_wait_r <= wait_val;
      out_rs_r   <= rs_nxt;
      out_en_r   <= en_nxt;
      out_dat_r  <= dat_nxt;
      out_last_r <= word.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_wait_r    <= RST_STARTUP_WAIT;
      second_key_wait_r <= RST_SECOND_KEY_WAIT;
      third_key_wait_r  <= RST_THIRD_KEY_WAIT;
      byte_gap_wait_r   <= RST_BYTE_GAP_WAIT;
      clear_done_wait_r <= RST_CLEAR_DONE_WAIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_STARTUP_WAIT:    startup_wait_r    <= cfg_data;
        REG_SECOND_KEY_WAIT: second_key_wait_r <= cfg_data;
        REG_THIRD_KEY_WAIT:  third_key_wait_r  <= cfg_data;
        REG_BYTE_GAP_WAIT:   byte_gap_wait_r   <= cfg_data;
        REG_CLEAR_DONE_WAIT: clear_done_wait_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_dat_r, out_en_r, out_wait_r};
  assign out_tuser  = out_rs_r;
  assign out_tlast  = out_last_r;

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && word.last) |=> state_r == S_IDLE)
    else $error("sequencer did not return to idle after last step");

  a_pc_in_rom: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> pc_r < PcWidth'(RomDepth))
    else $error("step counter left the control table");

  a_req_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load_req |=> (state_r == S_RUN && out_valid_r == $past(out_valid_r && !out_tready)))
    else $error("request did not start the sequencer");

  a_last_en_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> !out_tdata[17])
    else $error("request ended with EN high");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the character LCD nibble interface. Init, cursor,
// character and dropped requests are streamed in. A local expansion of each
// request into pin snapshots predicts every output transfer, field by field.
// The run steps through default, all-zero, all-max and random wait settings.
// Idle patterns change from phase to phase, and one phase has a long
// receiver stall.
// ----------------------------------------------------------------------------
module testbench
  import clcd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] KEY_8BIT         = 4'h3;
  localparam logic [3:0] KEY_4BIT         = 4'h2;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] LINE0_BASE       = 8'h80;
  localparam logic [7:0] LINE1_BASE       = 8'hC0;
  localparam int         SETTLE_CYCLES    = 64;
  localparam int         LONG_HOLD        = 400;

  typedef struct {
    req_type_t           kind;
    logic [5:0]          column;
    logic                row;
    logic [ByteWidth-1:0] char_code;
    bit                  drain;
  } lcd_req_t;

  typedef struct packed {
    logic [WaitWidth-1:0]   wait_before;
    logic                   rs;
    logic                   en;
    logic [NibbleWidth-1:0] nibble;
    logic                   last;
  } pin_event_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [15:0]            in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [23:0]            out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [RegIdxWidth-1:0] cfg_addr = '0;
  logic [CfgWidth-1:0]    cfg_data = '0;

  char_lcd_nibble_interface_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // local copy of the wait registers and pin levels
  logic [CfgWidth-1:0]    wait_startup = RST_STARTUP_WAIT;
  logic [CfgWidth-1:0]    wait_second  = RST_SECOND_KEY_WAIT;
  logic [CfgWidth-1:0]    wait_third   = RST_THIRD_KEY_WAIT;
  logic [CfgWidth-1:0]    wait_gap     = RST_BYTE_GAP_WAIT;
  logic [CfgWidth-1:0]    wait_clear   = RST_CLEAR_DONE_WAIT;
  logic                   pin_rs  = 1'b0;
  logic                   pin_en  = 1'b0;
  logic [NibbleWidth-1:0] pin_nib = '0;

  lcd_req_t   req_q[$];
  pin_event_t pin_q[$];
  lcd_req_t   offered;
  bit         offer_busy = 1'b0;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_go   = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  int mismatches = 0;
  int n_events   = 0;
  int n_init = 0, n_goto = 0, n_char = 0, n_dropped = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("char_lcd_nibble_interface_core test failed");
    $finish;
  end

  function automatic void push_pin_event(logic [WaitWidth-1:0] wait_before, logic last);
    pin_event_t ev;
    ev.wait_before = wait_before;
    ev.rs          = pin_rs;
    ev.en          = pin_en;
    ev.nibble      = pin_nib;
    ev.last        = last;
    pin_q.push_back(ev);
  endfunction

  function automatic void strobe_nibble(logic [NibbleWidth-1:0] value, logic last);
    pin_en = 1'b1;
    push_pin_event('0, 1'b0);
    pin_nib = value;
    push_pin_event('0, 1'b0);
    pin_en = 1'b0;
    push_pin_event('0, last);
  endfunction

  function automatic void send_key(logic [NibbleWidth-1:0] key, logic [CfgWidth-1:0] extra);
    pin_rs = 1'b0;
    push_pin_event(WaitWidth'(extra) + WaitWidth'(wait_gap), 1'b0);
    strobe_nibble(key, 1'b0);
  endfunction

  function automatic void send_byte(logic [ByteWidth-1:0] value, logic rs, logic last);
    pin_rs = rs;
    push_pin_event(WaitWidth'(wait_gap), 1'b0);
    strobe_nibble(value[7:4], 1'b0);
    strobe_nibble(value[3:0], last);
  endfunction

  function automatic void expand_request(lcd_req_t r);
    case (r.kind)
      REQ_INIT: begin
        n_init++;
        send_key(KEY_8BIT, wait_startup);
        send_key(KEY_8BIT, wait_second);
        send_key(KEY_8BIT, wait_third);
        send_key(KEY_4BIT, '0);
        send_byte(CMD_FUNCTION_SET, 1'b0, 1'b0);
        send_byte(CMD_DISPLAY_ON, 1'b0, 1'b0);
        send_byte(CMD_ENTRY_MODE, 1'b0, 1'b0);
        send_byte(CMD_CLEAR, 1'b0, 1'b0);
        push_pin_event(WaitWidth'(wait_clear), 1'b1);
      end
      REQ_GOTO: begin
        n_goto++;
        send_byte((r.row ? LINE1_BASE : LINE0_BASE) + ByteWidth'(r.column), 1'b0, 1'b1);
      end
      REQ_CHAR: begin
        n_char++;
        send_byte(r.char_code, 1'b1, 1'b1);
      end
      default: n_dropped++;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        expand_request(offered);
        offer_busy = 1'b0;
        offer = 1'b0;
      end
      if (!offer && req_q.size() != 0 && !(req_q[0].drain && pin_q.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        offered = req_q.pop_front();
        offer_busy = 1'b1;
        in_tdata <= {1'b0, offered.char_code, offered.row, offered.column};
        in_tuser <= offered.kind;
        offer = 1'b1;
      end
      in_tvalid <= offer;
    end
  end

  // pin event monitor
  always @(posedge clk) begin
    pin_event_t want;
    pin_event_t got;
    logic       ready;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_events++;
        got = '{out_tdata[16:0], out_tuser, out_tdata[17], out_tdata[21:18], out_tlast};
        if (pin_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer wait=%0d rs=%b en=%b nib=%h last=%b", $time,
                   got.wait_before, got.rs, got.en, got.nibble, got.last);
        end else begin
          want = pin_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: expected wait=%0d rs=%b en=%b nib=%h last=%b", $time,
                     want.wait_before, want.rs, want.en, want.nibble, want.last);
            $display("%0t: actual   wait=%0d rs=%b en=%b nib=%h last=%b", $time,
                     got.wait_before, got.rs, got.en, got.nibble, got.last);
          end
        end
      end
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else begin
        ready = $urandom_range(99) >= recv_idle_pct;
      end
      out_tready <= ready;
    end
  end

  task automatic queue_request(req_type_t kind, logic [5:0] column, logic row,
                               logic [7:0] char_code);
    lcd_req_t r;
    r.kind      = kind;
    r.column    = column;
    r.row       = row;
    r.char_code = char_code;
    r.drain     = 1'b0;
    req_q.push_back(r);
  endtask

  function automatic lcd_req_t random_request(bit drain);
    lcd_req_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 4) r.kind = REQ_INIT;
    else if (pick < 34) r.kind = REQ_GOTO;
    else if (pick < 90) r.kind = REQ_CHAR;
    else r.kind = REQ_NONE;
    r.column    = 6'($urandom_range(63));
    r.row       = 1'($urandom_range(1));
    r.char_code = 8'($urandom_range(255));
    r.drain     = drain;
    return r;
  endfunction

  task automatic drain_bench();
    while (req_q.size() != 0 || offer_busy || pin_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] startup, logic [15:0] second, logic [15:0] third,
                              logic [15:0] gap, logic [15:0] clear);
    logic [RegIdxWidth-1:0] idx[5] = '{REG_STARTUP_WAIT, REG_SECOND_KEY_WAIT,
                                       REG_THIRD_KEY_WAIT, REG_BYTE_GAP_WAIT,
                                       REG_CLEAR_DONE_WAIT};
    logic [CfgWidth-1:0]    vals[5];
    vals = '{startup, second, third, gap, clear};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_STARTUP_WAIT:    wait_startup = vals[i];
        REG_SECOND_KEY_WAIT: wait_second  = vals[i];
        REG_THIRD_KEY_WAIT:  wait_third   = vals[i];
        REG_BYTE_GAP_WAIT:   wait_gap     = vals[i];
        default:             wait_clear   = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_wait();
    return 16'($urandom_range(65535));
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests at the reset wait values
    queue_request(REQ_CHAR, 6'd0, 1'b0, 8'h00);
    queue_request(REQ_INIT, 6'd63, 1'b1, 8'hFF);
    queue_request(REQ_GOTO, 6'd0, 1'b0, 8'h00);
    queue_request(REQ_GOTO, 6'd63, 1'b1, 8'hFF);
    queue_request(REQ_GOTO, 6'd63, 1'b0, 8'h5A);
    queue_request(REQ_GOTO, 6'd0, 1'b1, 8'hA5);
    queue_request(REQ_CHAR, 6'd63, 1'b1, 8'hFF);
    queue_request(REQ_CHAR, 6'd21, 1'b0, 8'hA5);
    queue_request(REQ_NONE, 6'd63, 1'b1, 8'hFF);
    queue_request(REQ_CHAR, 6'd42, 1'b1, 8'h5A);
    queue_request(REQ_INIT, 6'd0, 1'b0, 8'h00);
    queue_request(REQ_NONE, 6'd0, 1'b0, 8'h00);
    queue_request(REQ_CHAR, 6'd7, 1'b0, 8'h80);
    drain_bench();

    program_regs('0, '0, '0, '0, '0);
    queue_request(REQ_INIT, 6'd17, 1'b0, 8'h3C);
    queue_request(REQ_CHAR, 6'd0, 1'b1, 8'h3C);
    queue_request(REQ_GOTO, 6'd33, 1'b1, 8'h00);
    drain_bench();

    program_regs('1, '1, '1, '1, '1);
    queue_request(REQ_INIT, 6'd1, 1'b1, 8'hC3);
    queue_request(REQ_CHAR, 6'd2, 1'b0, 8'h7E);
    queue_request(REQ_GOTO, 6'd42, 1'b1, 8'h01);
    drain_bench();

    // sender mostly busy, receiver mostly stalled, one long hold
    program_regs(rand_wait(), rand_wait(), rand_wait(), rand_wait(), rand_wait());
    send_idle_pct <= 9;
    recv_idle_pct <= 78;
    for (int i = 0; i < 120; i++) req_q.push_back(random_request(1'b0));
    hold_go <= 1'b1;
    drain_bench();

    // sender mostly idle, receiver mostly ready, some pauses until empty
    program_regs('1, '0, rand_wait(), '0, '1);
    send_idle_pct <= 78;
    recv_idle_pct <= 9;
    for (int i = 0; i < 120; i++) req_q.push_back(random_request(i % 40 == 39));
    drain_bench();

    // back to back
    program_regs(rand_wait(), rand_wait(), rand_wait(), 16'($urandom_range(3)), rand_wait());
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    for (int i = 0; i < 130; i++) req_q.push_back(random_request(1'b0));
    drain_bench();

    $display("covered %0d init, %0d goto, %0d character and %0d dropped requests",
             n_init, n_goto, n_char, n_dropped);
    $display("checked %0d pin events over six wait settings", n_events);
    if (pin_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d pin events never arrived", $time, pin_q.size());
    end
    if (mismatches == 0) begin
      $display("char_lcd_nibble_interface_core test passed");
    end else begin
      $display("char_lcd_nibble_interface_core test failed");
    end
    $finish;
  end

endmodule

>>> char_lcd_nibble_interface_core.f
rtl/clcd_pkg.sv
rtl/char_lcd_nibble_interface_core.sv
bench/testbench.sv
